### rtl/assert_macros.svh
// assertion macros shared by the tokenizer rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// plain property check under reset
`define ASSERT_PROP(label, clock, resetn, prop, msg) \
    label: assert property (@(posedge clock) disable iff (!resetn) prop) else $error(msg);
// same-cycle implication
`define ASSERT_IMPL(label, clock, resetn, ante, cons, msg) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define ASSERT_NEXT(label, clock, resetn, ante, cons, msg) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_PROP(label, clock, resetn, prop, msg)
`define ASSERT_IMPL(label, clock, resetn, ante, cons, msg)
`define ASSERT_NEXT(label, clock, resetn, ante, cons, msg)
`endif

`endif

### rtl/slt_pkg.sv
// types and constants of the shell line tokenizer
`default_nettype none

package slt_pkg;

    // result kinds
    localparam logic [1:0] KIND_ARG     = 2'd0;
    localparam logic [1:0] KIND_TARGET  = 2'd1;
    localparam logic [1:0] KIND_SUMMARY = 2'd2;

    // characters with a meaning to the parser
    localparam logic [7:0] CH_EOL    = 8'h00;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_SEMI   = 8'h3B;

    // scanner position within the line
    typedef enum logic [2:0] {
        MODE_BETWEEN,
        MODE_PLAIN,
        MODE_DQUOTE,
        MODE_SQUOTE,
        MODE_STOPPED
    } scan_mode_t;

    // controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_PRIME,
        S_BYTES,
        S_SUM
    } ctrl_state_t;

    // controller to datapath
    typedef struct packed {
        logic step;
        logic load_byte;
        logic load_sum;
    } slt_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic word_go;
        logic eol;
        logic last_byte;
        logic out_free;
    } slt_sts_t;

endpackage

`default_nettype wire

### rtl/slt_ram.sv
// generic single write port ram with registered read
`default_nettype none

module slt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### rtl/slt_ctrl.sv
// controller state machine of the shell line tokenizer
`default_nettype none
`include "assert_macros.svh"

module slt_ctrl
    import slt_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     s_tvalid,
    output logic          s_tready,
    input  wire slt_sts_t sts,
    output slt_cmd_t      cmd
);

    ctrl_state_t state_reg, state_next;
    logic        eol_pend_reg, eol_pend_next;

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            eol_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            eol_pend_reg <= eol_pend_next;
        end
    end

    // next state
    always_comb
    begin
        state_next    = state_reg;
        eol_pend_next = eol_pend_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    eol_pend_next = sts.eol;
                    if (sts.word_go)
                    begin
                        state_next = S_PRIME;
                    end
                    else if (sts.eol)
                    begin
                        state_next = S_SUM;
                    end
                end
            end
            S_PRIME:
            begin
                state_next = S_BYTES;
            end
            S_BYTES:
            begin
                if (sts.out_free && sts.last_byte)
                begin
                    state_next = eol_pend_reg ? S_SUM : S_IDLE;
                end
            end
            S_SUM:
            begin
                if (sts.out_free)
                begin
                    state_next    = S_IDLE;
                    eol_pend_next = 1'b0;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        s_tready      = 1'b0;
        cmd.step      = 1'b0;
        cmd.load_byte = 1'b0;
        cmd.load_sum  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                cmd.step = s_tvalid;
            end
            S_PRIME:
            begin
            end
            S_BYTES:
            begin
                cmd.load_byte = sts.out_free;
            end
            S_SUM:
            begin
                cmd.load_sum = sts.out_free;
            end
            default:
            begin
            end
        endcase
    end

    `ASSERT_PROP(a_one_cmd, clk, rst_n, $onehot0({cmd.step, cmd.load_byte, cmd.load_sum}), "more than one datapath command")
    `ASSERT_NEXT(a_prime_once, clk, rst_n, state_reg == S_PRIME, state_reg == S_BYTES, "prime cycle not followed by drain")
    `ASSERT_NEXT(a_drain_ends, clk, rst_n, cmd.load_byte && sts.last_byte, state_reg != S_BYTES, "drain kept going after the last byte")

endmodule

`default_nettype wire

### rtl/slt_dp.sv
// parser datapath, word buffer and output register of the tokenizer
`default_nettype none
`include "assert_macros.svh"

module slt_dp
    import slt_pkg::*;
#(
    parameter int MAX_ARGS    = 16,
    parameter int TOKEN_BYTES = 32,
    parameter int LINE_BYTES  = 256
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic [7:0]  s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,
    output logic [1:0]       m_tuser,
    output logic             m_tlast,
    input  wire slt_cmd_t    cmd,
    output slt_sts_t         sts
);

    localparam int LW = $clog2(TOKEN_BYTES);
    localparam int AW = $clog2(MAX_ARGS + 1);
    localparam int UW = $clog2(LINE_BYTES);
    localparam int SW = ((UW > LW) ? UW : LW) + 2;

    // line state
    scan_mode_t      mode_reg, mode_next;
    logic            gt_reg, gt_next;
    logic            tgt_reg, tgt_next;
    logic            redir_reg, redir_next;
    logic            app_reg, app_next;
    logic [LW-1:0]   len_reg, len_next;
    logic [AW-1:0]   args_reg, args_next;
    logic [UW-1:0]   used_reg, used_next;

    // drain state
    logic [LW-1:0]   dlen_reg, dlen_next;
    logic [1:0]      dkind_reg, dkind_next;
    logic [3:0]      dnum_reg, dnum_next;
    logic [LW-1:0]   rd_idx_reg, rd_idx_next;

    // output register
    logic            ovalid_reg;
    logic [1:0]      okind_reg;
    logic [7:0]      obyte_reg;
    logic [3:0]      onum_reg;
    logic            olast_reg;
    logic [4:0]      ocount_reg;
    logic            oredir_reg;
    logic            oapp_reg;

    // buffer ports
    logic            we;
    logic [LW-1:0]   waddr;
    logic [LW-1:0]   raddr;
    logic [7:0]      rdata;

    // status to the controller
    logic            word_go;
    logic            eol;
    logic            last_byte;
    logic            out_free;

    // word finish outcome
    logic            gt_take;
    logic            tgt_eff;
    logic            fin_emit;
    logic            fin_stop;
    logic [1:0]      fin_kind;
    logic [AW-1:0]   fin_args;
    logic [UW-1:0]   fin_used;
    logic            fin_redir;
    logic [SW-1:0]   need;
    logic [AW-1:0]   args_inc;

    // step decisions
    logic            fin;
    logic            add;
    logic            stop_now;
    logic            start;
    scan_mode_t      start_mode;
    logic            between;
    logic            blank;
    logic            delim;
    logic [7:0]      quote;

    slt_ram #(
        .WIDTH (8),
        .DEPTH (TOKEN_BYTES)
    ) u_buf (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (s_tdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    // what finishing the current word would do
    always_comb
    begin
        gt_take   = (s_tdata != CH_EOL) && (mode_reg != MODE_STOPPED) && gt_reg;
        tgt_eff   = gt_take | tgt_reg;
        need      = SW'(used_reg) + SW'(len_reg) + SW'(1);
        args_inc  = args_reg + AW'(1);
        fin_emit  = 1'b0;
        fin_stop  = 1'b0;
        fin_kind  = KIND_ARG;
        fin_args  = args_reg;
        fin_used  = used_reg;
        fin_redir = redir_reg;
        if (tgt_eff)
        begin
            fin_kind = KIND_TARGET;
            fin_stop = 1'b1;
            if (len_reg != '0)
            begin
                fin_emit  = 1'b1;
                fin_redir = 1'b1;
            end
        end
        else if (len_reg != '0)
        begin
            if (need >= SW'(LINE_BYTES))
            begin
                fin_stop = 1'b1;
            end
            else
            begin
                fin_emit = 1'b1;
                fin_args = args_inc;
                fin_used = UW'(need);
                fin_stop = (args_inc >= AW'(MAX_ARGS));
            end
        end
    end

    // character classification
    always_comb
    begin
        blank = (s_tdata == CH_SPACE) || (s_tdata == CH_TAB);
        delim = blank || (s_tdata == CH_GT) || (s_tdata == CH_SEMI);
        quote = (mode_reg == MODE_DQUOTE) ? CH_DQUOTE : CH_SQUOTE;
    end

    // per-character parse step
    always_comb
    begin
        fin        = 1'b0;
        add        = 1'b0;
        stop_now   = 1'b0;
        start      = 1'b0;
        start_mode = MODE_PLAIN;
        between    = 1'b0;
        eol        = 1'b0;
        gt_next    = gt_reg;
        tgt_next   = tgt_reg;
        app_next   = app_reg;
        if (s_tdata == CH_EOL)
        begin
            eol = 1'b1;
            fin = (mode_reg == MODE_PLAIN) || (mode_reg == MODE_DQUOTE)
                  || (mode_reg == MODE_SQUOTE);
        end
        else if (mode_reg == MODE_STOPPED)
        begin
        end
        else if (gt_take && (s_tdata == CH_GT))
        begin
            gt_next  = 1'b0;
            tgt_next = 1'b1;
            app_next = 1'b1;
        end
        else
        begin
            if (gt_take)
            begin
                gt_next  = 1'b0;
                tgt_next = 1'b1;
                app_next = 1'b0;
            end
            case (mode_reg)
                MODE_DQUOTE, MODE_SQUOTE:
                begin
                    if (s_tdata == quote)
                    begin
                        fin = 1'b1;
                    end
                    else
                    begin
                        add = 1'b1;
                    end
                end
                MODE_PLAIN:
                begin
                    if (!delim)
                    begin
                        add = 1'b1;
                    end
                    else
                    begin
                        fin     = 1'b1;
                        between = !fin_stop;
                    end
                end
                MODE_BETWEEN:
                begin
                    between = 1'b1;
                end
                default:
                begin
                end
            endcase
            // start of something new between words
            if (between && !blank)
            begin
                if (s_tdata == CH_SEMI)
                begin
                    stop_now = 1'b1;
                end
                else if (s_tdata == CH_GT)
                begin
                    if (tgt_eff)
                    begin
                        stop_now = 1'b1;
                    end
                    else
                    begin
                        gt_next = 1'b1;
                    end
                end
                else
                begin
                    start = 1'b1;
                    if (s_tdata == CH_DQUOTE)
                    begin
                        start_mode = MODE_DQUOTE;
                    end
                    else if (s_tdata == CH_SQUOTE)
                    begin
                        start_mode = MODE_SQUOTE;
                    end
                end
            end
        end
    end

    // apply the step to the line state
    always_comb
    begin
        mode_next   = mode_reg;
        len_next    = len_reg;
        args_next   = args_reg;
        used_next   = used_reg;
        redir_next  = redir_reg;
        dlen_next   = dlen_reg;
        dkind_next  = dkind_reg;
        dnum_next   = dnum_reg;
        rd_idx_next = rd_idx_reg;
        word_go     = 1'b0;
        we          = 1'b0;
        waddr       = len_reg;
        if (fin)
        begin
            len_next   = '0;
            mode_next  = fin_stop ? MODE_STOPPED : MODE_BETWEEN;
            args_next  = fin_args;
            used_next  = fin_used;
            redir_next = fin_redir;
            if (fin_emit)
            begin
                word_go     = 1'b1;
                dlen_next   = len_reg;
                dkind_next  = fin_kind;
                dnum_next   = (fin_kind == KIND_ARG) ? 4'(args_reg) : 4'd0;
                rd_idx_next = '0;
            end
        end
        if (add && (len_reg < LW'(TOKEN_BYTES - 1)))
        begin
            we       = cmd.step;
            len_next = len_reg + LW'(1);
        end
        if (stop_now)
        begin
            mode_next = MODE_STOPPED;
        end
        if (start)
        begin
            mode_next = start_mode;
            len_next  = '0;
            if (start_mode == MODE_PLAIN)
            begin
                we       = cmd.step;
                waddr    = '0;
                len_next = LW'(1);
            end
        end
        if (cmd.load_byte)
        begin
            rd_idx_next = rd_idx_reg + LW'(1);
        end
    end

    // drain read address runs one ahead when a byte is taken
    assign raddr = cmd.load_byte ? (rd_idx_reg + LW'(1)) : rd_idx_reg;

    assign last_byte = ((LW + 1)'(rd_idx_reg) + (LW + 1)'(1)) == (LW + 1)'(dlen_reg);
    assign out_free  = !ovalid_reg || m_tready;

    // status bundle
    assign sts = '{word_go: word_go, eol: eol, last_byte: last_byte, out_free: out_free};

    // line state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_BETWEEN;
            gt_reg    <= 1'b0;
            tgt_reg   <= 1'b0;
            redir_reg <= 1'b0;
            app_reg   <= 1'b0;
            len_reg   <= '0;
            args_reg  <= '0;
            used_reg  <= '0;
        end
        else if (cmd.load_sum)
        begin
            mode_reg  <= MODE_BETWEEN;
            gt_reg    <= 1'b0;
            tgt_reg   <= 1'b0;
            redir_reg <= 1'b0;
            app_reg   <= 1'b0;
            len_reg   <= '0;
            args_reg  <= '0;
            used_reg  <= '0;
        end
        else if (cmd.step)
        begin
            mode_reg  <= mode_next;
            gt_reg    <= gt_next;
            tgt_reg   <= tgt_next;
            redir_reg <= redir_next;
            app_reg   <= app_next;
            len_reg   <= len_next;
            args_reg  <= args_next;
            used_reg  <= used_next;
        end
    end

    // drain bookkeeping
    always_ff @(posedge clk)
    begin
        if (cmd.step)
        begin
            dlen_reg  <= dlen_next;
            dkind_reg <= dkind_next;
            dnum_reg  <= dnum_next;
        end
        if (cmd.step || cmd.load_byte)
        begin
            rd_idx_reg <= rd_idx_next;
        end
    end

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovalid_reg <= 1'b0;
        end
        else if (cmd.load_byte || cmd.load_sum)
        begin
            ovalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            ovalid_reg <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (cmd.load_byte)
        begin
            okind_reg  <= dkind_reg;
            obyte_reg  <= rdata;
            onum_reg   <= dnum_reg;
            olast_reg  <= last_byte;
            ocount_reg <= 5'(args_reg);
            oredir_reg <= redir_reg;
            oapp_reg   <= redir_reg & app_reg;
        end
        else if (cmd.load_sum)
        begin
            okind_reg  <= KIND_SUMMARY;
            obyte_reg  <= 8'd0;
            onum_reg   <= 4'd0;
            olast_reg  <= 1'b1;
            ocount_reg <= 5'(args_reg);
            oredir_reg <= redir_reg;
            oapp_reg   <= redir_reg & app_reg;
        end
    end

    assign m_tvalid = ovalid_reg;
    assign m_tuser  = okind_reg;
    assign m_tlast  = olast_reg;
    assign m_tdata  = {5'd0, oapp_reg, oredir_reg, ocount_reg, onum_reg, obyte_reg};

    `ASSERT_IMPL(a_rd_in_word, clk, rst_n, cmd.load_byte, rd_idx_reg < dlen_reg,
                 "buffer read past the end of the word")
    `ASSERT_IMPL(a_full_stops, clk, rst_n, args_reg == AW'(MAX_ARGS),
                 mode_reg == MODE_STOPPED, "argument count full but parsing goes on")
    `ASSERT_IMPL(a_redir_stops, clk, rst_n, redir_reg, mode_reg == MODE_STOPPED,
                 "redirect taken but parsing goes on")

endmodule

`default_nettype wire

### rtl/shell_line_tokenizer_top.sv
// top level of the shell line tokenizer
//
// Input stream: one command line character per request on s_tdata, 0 ends
// the line. Output stream: word bytes (tuser 0 argument, 1 redirect target)
// and one line summary (tuser 2) per line; tlast marks the final byte of a
// word and the summary.
// A character that emits no word is taken in S_IDLE, and the controller stays
// there. A character that ends an emitted word moves the controller through
// S_PRIME, which primes the word buffer read, then S_BYTES, in which the
// buffer gives one byte per cycle into the output register while the output
// is free; no new character is taken until the last byte is loaded. End of
// line then holds the input through S_SUM for the summary; a summary with no
// word before it goes from S_IDLE straight to S_SUM.
// When the receiver stalls, the output register holds its request and the
// drain waits; input is still taken as long as no word or summary is waiting.
// Reset clears the line state and the output valid; the word buffer needs no
// clearing since a word is always written before it is read.
`default_nettype none

module shell_line_tokenizer_top
    import slt_pkg::*;
#(
    parameter int MAX_ARGS    = 16,
    parameter int TOKEN_BYTES = 32,
    parameter int LINE_BYTES  = 256
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] ch
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // [7:0] byte_value, [11:8] arg_number,
                                        // [16:12] arg_count, [17] has_redirect,
                                        // [18] append_mode
    output logic [1:0]       m_tuser,   // [1:0] kind
    output logic             m_tlast    // last_byte
);

    slt_cmd_t cmd;
    slt_sts_t sts;

    slt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    slt_dp #(
        .MAX_ARGS    (MAX_ARGS),
        .TOKEN_BYTES (TOKEN_BYTES),
        .LINE_BYTES  (LINE_BYTES)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .cmd      (cmd),
        .sts      (sts)
    );

endmodule

`default_nettype wire

### tb/sv/testbench.sv
// self-checking testbench for the shell line tokenizer: directed lines, heavy lines under a hold-off, then random lines
module testbench;
    import slt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_ARGS    = 16;
    localparam int TOKEN_BYTES = 32;
    localparam int LINE_BYTES  = 256;
    localparam int RANDOM_CHARS = 220;
    localparam int HOLD_CYCLES  = 400;

    // one output request, fields as they leave the block
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] value;
        logic [3:0] argn;
        logic       last;
        logic [4:0] count;
        logic       redir;
        logic       app;
    } tok_out_t;

    // one row of the directed part
    typedef struct packed {
        logic [7:0] ch;
        logic       typed;
        tok_out_t   res;
    } dir_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    shell_line_tokenizer_top #(
        .MAX_ARGS    (MAX_ARGS),
        .TOKEN_BYTES (TOKEN_BYTES),
        .LINE_BYTES  (LINE_BYTES)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #4 clk = ~clk;

    // line state mirrored from the block
    scan_mode_t line_mode;
    logic       gt_pend;
    logic       tgt_mode;
    logic [7:0] word_buf [TOKEN_BYTES];
    int         word_len;
    int         arg_total;
    int         store_used;
    logic       redir_seen;
    logic       append_seen;

    tok_out_t   token_out_q [$];
    dir_row_t   dir_rows [$];
    logic [7:0] line_q [$];

    int  idle_pct = 0;
    int  stall_pct = 0;
    bit  hold_go = 1'b0;
    int  hold_left = 0;
    int  mismatches = 0;
    int  chars_sent = 0;
    int  lines_sent = 0;
    int  results_checked = 0;
    int  redirect_lines = 0;
    int  full_count_lines = 0;

    function void clear_line();
        line_mode   = MODE_BETWEEN;
        gt_pend     = 1'b0;
        tgt_mode    = 1'b0;
        word_len    = 0;
        arg_total   = 0;
        store_used  = 0;
        redir_seen  = 1'b0;
        append_seen = 1'b0;
    endfunction

    function void queue_result(logic [1:0] k, logic [7:0] v, logic [3:0] n, logic lst);
        tok_out_t r;
        r.kind  = k;
        r.value = v;
        r.argn  = n;
        r.last  = lst;
        r.count = arg_total[4:0];
        r.redir = redir_seen;
        r.app   = redir_seen & append_seen;
        token_out_q.push_back(r);
    endfunction

    // excess characters of an over-long word are dropped
    function void add_char(logic [7:0] c);
        if (word_len < TOKEN_BYTES - 1) begin
            word_buf[word_len] = c;
            word_len++;
        end
    endfunction

    function void send_word(int len, logic [1:0] k, logic [3:0] n);
        for (int i = 0; i < len; i++)
            queue_result(k, word_buf[i], n, (i + 1 == len));
    endfunction

    // ends the current word as an argument or as the redirect target
    function void close_word();
        int len;
        len = word_len;
        word_len = 0;
        if (tgt_mode) begin
            if (len > 0) begin
                redir_seen = 1'b1;
                send_word(len, KIND_TARGET, 4'd0);
            end
            line_mode = MODE_STOPPED;
            return;
        end
        line_mode = MODE_BETWEEN;
        if (len == 0)
            return;
        if (store_used + len + 1 >= LINE_BYTES) begin
            line_mode = MODE_STOPPED;
            return;
        end
        arg_total++;
        send_word(len, KIND_ARG, 4'(arg_total - 1));
        store_used += len + 1;
        if (arg_total >= MAX_ARGS)
            line_mode = MODE_STOPPED;
    endfunction

    // expected requests caused by one accepted character
    function void tokenize_char(logic [7:0] c);
        logic [7:0] q;
        logic       blank;
        blank = (c == CH_SPACE) || (c == CH_TAB);
        if (c == CH_EOL) begin
            if (line_mode == MODE_PLAIN || line_mode == MODE_DQUOTE ||
                line_mode == MODE_SQUOTE)
                close_word();
            if (redir_seen)
                redirect_lines++;
            if (arg_total >= MAX_ARGS)
                full_count_lines++;
            queue_result(KIND_SUMMARY, 8'h00, 4'd0, 1'b1);
            clear_line();
            return;
        end
        if (line_mode == MODE_STOPPED)
            return;
        // character right after '>' decides between '>' and '>>'
        if (gt_pend) begin
            gt_pend  = 1'b0;
            tgt_mode = 1'b1;
            if (c == CH_GT) begin
                append_seen = 1'b1;
                return;
            end
            append_seen = 1'b0;
        end
        if (line_mode == MODE_DQUOTE || line_mode == MODE_SQUOTE) begin
            q = (line_mode == MODE_DQUOTE) ? CH_DQUOTE : CH_SQUOTE;
            if (c == q)
                close_word();
            else
                add_char(c);
            return;
        end
        if (line_mode == MODE_PLAIN) begin
            if (!blank && c != CH_GT && c != CH_SEMI) begin
                add_char(c);
                return;
            end
            close_word();
            if (line_mode == MODE_STOPPED)
                return;
        end
        // between words
        if (blank)
            return;
        if (c == CH_SEMI) begin
            line_mode = MODE_STOPPED;
            return;
        end
        if (c == CH_GT) begin
            if (tgt_mode)
                line_mode = MODE_STOPPED;
            else
                gt_pend = 1'b1;
            return;
        end
        word_len = 0;
        if (c == CH_DQUOTE)
            line_mode = MODE_DQUOTE;
        else if (c == CH_SQUOTE)
            line_mode = MODE_SQUOTE;
        else begin
            line_mode = MODE_PLAIN;
            add_char(c);
        end
    endfunction

    // offer one character, predict at acceptance; typed rows replace the prediction
    task send_char(input logic [7:0] ch, input logic typed, input tok_out_t res);
        int n0;
        while ($urandom_range(0, 99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        n0 = token_out_q.size();
        tokenize_char(ch);
        if (typed) begin
            while (token_out_q.size() > n0)
                void'(token_out_q.pop_back());
            token_out_q.push_back(res);
        end
        chars_sent++;
    endtask

    task send_line();
        foreach (line_q[i])
            send_char(line_q[i], 1'b0, '0);
        lines_sent++;
        line_q.delete();
    endtask

    // character that may sit inside an unquoted word
    function logic [7:0] plain_char(bit first);
        logic [7:0] c;
        do
            c = 8'($urandom_range(1, 255));
        while (c == CH_SPACE || c == CH_TAB || c == CH_GT || c == CH_SEMI ||
               (first && (c == CH_DQUOTE || c == CH_SQUOTE)));
        return c;
    endfunction

    function logic [7:0] quoted_char(logic [7:0] q);
        logic [7:0] c;
        do
            c = 8'($urandom_range(1, 255));
        while (c == q);
        return c;
    endfunction

    function logic [7:0] blank_char();
        return $urandom_range(0, 1) ? CH_SPACE : CH_TAB;
    endfunction

    function int word_size(int lo);
        return ($urandom_range(0, 9) == 0) ? $urandom_range(28, 40) : $urandom_range(lo, 6);
    endfunction

    function void add_junk(int hi);
        repeat ($urandom_range(0, hi))
            line_q.push_back(8'($urandom_range(1, 255)));
    endfunction

    // words, quotes and an optional redirect or ';', with random content
    function void build_shaped_line();
        int nwords, len, style;
        logic [7:0] q;
        nwords = $urandom_range(0, 6);
        for (int w = 0; w < nwords; w++) begin
            repeat ($urandom_range(0, 2))
                line_q.push_back(blank_char());
            style = $urandom_range(0, 9);
            if (style < 6) begin
                len = word_size(1);
                for (int i = 0; i < len; i++)
                    line_q.push_back(plain_char(i == 0));
            end else begin
                q = (style < 8) ? CH_DQUOTE : CH_SQUOTE;
                len = word_size(0);
                line_q.push_back(q);
                for (int i = 0; i < len; i++)
                    line_q.push_back(quoted_char(q));
                if ($urandom_range(0, 9) != 0 || w != nwords - 1)
                    line_q.push_back(q);
            end
            line_q.push_back(blank_char());
        end
        style = $urandom_range(0, 9);
        if (style < 4) begin
            line_q.push_back(CH_GT);
            if ($urandom_range(0, 1))
                line_q.push_back(CH_GT);
            if ($urandom_range(0, 1))
                line_q.push_back(blank_char());
            case ($urandom_range(0, 9))
                0: line_q.push_back(CH_GT);
                1: line_q.push_back(CH_SEMI);
                2: ;
                default: begin
                    len = word_size(1);
                    for (int i = 0; i < len; i++)
                        line_q.push_back(plain_char(i == 0));
                end
            endcase
            add_junk(3);
        end else if (style < 6) begin
            line_q.push_back(CH_SEMI);
            add_junk(3);
        end
        line_q.push_back(CH_EOL);
    endfunction

    // any bytes, with the parser's special characters made frequent
    function void build_noise_line();
        repeat ($urandom_range(1, 14)) begin
            case ($urandom_range(0, 11))
                0: line_q.push_back(CH_SPACE);
                1: line_q.push_back(CH_TAB);
                2: line_q.push_back(CH_DQUOTE);
                3: line_q.push_back(CH_SQUOTE);
                4: line_q.push_back(CH_GT);
                5: line_q.push_back(CH_SEMI);
                default: line_q.push_back(8'($urandom_range(1, 255)));
            endcase
        end
        line_q.push_back(CH_EOL);
    endfunction

    // long words until the argument store overflows
    function void build_storage_line();
        repeat (9) begin
            repeat ($urandom_range(31, 34))
                line_q.push_back(8'($urandom_range(8'h61, 8'h7a)));
            line_q.push_back(blank_char());
        end
        line_q.push_back(CH_EOL);
    endfunction

    // one-letter words past the argument limit
    function void build_count_line();
        for (int i = 0; i < MAX_ARGS + 2; i++) begin
            line_q.push_back(8'(8'h61 + i));
            line_q.push_back(CH_SPACE);
        end
        line_q.push_back(CH_EOL);
    endfunction

    function void check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // receiver: random stalls plus one long hold-off on request
    always @(posedge clk) begin
        if (hold_go) begin
            hold_go = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else
            m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // compare each accepted output request with the oldest prediction
    always @(posedge clk) begin : monitor
        tok_out_t want;
        if (rst_n && m_tvalid && m_tready) begin
            if (token_out_q.size() == 0) begin
                $error("unexpected output: tuser %0d tdata %h tlast %0d",
                       m_tuser, m_tdata, m_tlast);
                mismatches++;
            end else begin
                want = token_out_q.pop_front();
                check_field("kind", want.kind, m_tuser);
                check_field("byte_value", want.value, m_tdata[7:0]);
                check_field("arg_number", want.argn, m_tdata[11:8]);
                check_field("last_byte", want.last, m_tlast);
                check_field("arg_count", want.count, m_tdata[16:12]);
                check_field("has_redirect", want.redir, m_tdata[17]);
                check_field("append_mode", want.app, m_tdata[18]);
                check_field("tdata padding", 0, m_tdata[23:19]);
                results_checked++;
            end
        end
    end

    initial begin
        #4_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        int target;
        clear_line();

        // directed lines: extremes, quoting, redirects, stop and end-of-line cases
        dir_rows.push_back('{CH_EOL, 1'b1, '{KIND_SUMMARY, 8'h00, 4'd0, 1'b1, 5'd0, 1'b0, 1'b0}});
        dir_rows.push_back('{8'h61, 1'b0, '0});
        dir_rows.push_back('{CH_SPACE, 1'b1, '{KIND_ARG, 8'h61, 4'd0, 1'b1, 5'd1, 1'b0, 1'b0}});
        dir_rows.push_back('{8'hFF, 1'b0, '0});
        dir_rows.push_back('{8'h01, 1'b0, '0});
        dir_rows.push_back('{CH_TAB, 1'b0, '0});
        dir_rows.push_back('{CH_DQUOTE, 1'b0, '0});
        dir_rows.push_back('{CH_SPACE, 1'b0, '0});
        dir_rows.push_back('{8'h80, 1'b0, '0});
        dir_rows.push_back('{CH_DQUOTE, 1'b0, '0});
        // empty quoted word is dropped
        dir_rows.push_back('{CH_SQUOTE, 1'b0, '0});
        dir_rows.push_back('{CH_SQUOTE, 1'b0, '0});
        // a third '>' leaves the target empty and stops the line
        dir_rows.push_back('{CH_GT, 1'b0, '0});
        dir_rows.push_back('{CH_GT, 1'b0, '0});
        dir_rows.push_back('{CH_GT, 1'b0, '0});
        dir_rows.push_back('{8'h7F, 1'b0, '0});
        dir_rows.push_back('{CH_EOL, 1'b1, '{KIND_SUMMARY, 8'h00, 4'd0, 1'b1, 5'd3, 1'b0, 1'b0}});
        // unclosed quote finished by end of line
        dir_rows.push_back('{CH_SQUOTE, 1'b0, '0});
        dir_rows.push_back('{8'h41, 1'b0, '0});
        dir_rows.push_back('{CH_EOL, 1'b0, '0});
        // argument, then redirect target ended by ';'
        dir_rows.push_back('{8'h62, 1'b0, '0});
        dir_rows.push_back('{CH_GT, 1'b0, '0});
        dir_rows.push_back('{8'h66, 1'b0, '0});
        dir_rows.push_back('{CH_SEMI, 1'b0, '0});
        dir_rows.push_back('{CH_EOL, 1'b0, '0});
        // ';' at line start stops at once
        dir_rows.push_back('{CH_SEMI, 1'b0, '0});
        dir_rows.push_back('{CH_EOL, 1'b1, '{KIND_SUMMARY, 8'h00, 4'd0, 1'b1, 5'd0, 1'b0, 1'b0}});

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_char(dir_rows[i].ch, dir_rows[i].typed, dir_rows[i].res);
        lines_sent += 5;

        // heavy lines with the receiver held off, so the block backs up
        hold_go = 1'b1;
        build_storage_line();
        send_line();
        build_count_line();
        send_line();

        // random lines over four idling phases
        target = chars_sent;
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 62; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 62; end
                default: begin idle_pct = 19; stall_pct = 19; end
            endcase
            target += RANDOM_CHARS / 4;
            while (chars_sent < target) begin
                if ($urandom_range(0, 3) == 0)
                    build_noise_line();
                else
                    build_shaped_line();
                send_line();
            end
        end
        s_tvalid <= 1'b0;
        idle_pct = 0;
        stall_pct = 0;

        while (token_out_q.size() != 0)
            @(posedge clk);
        repeat (64) @(posedge clk);

        $display("sent %0d characters in %0d lines, checked %0d output requests",
                 chars_sent, lines_sent, results_checked);
        $display("lines with a redirect: %0d, lines reaching the argument limit: %0d",
                 redirect_lines, full_count_lines);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

### sim.f
+incdir+rtl
rtl/slt_pkg.sv
rtl/slt_ram.sv
rtl/slt_ctrl.sv
rtl/slt_dp.sv
rtl/shell_line_tokenizer_top.sv
tb/sv/testbench.sv
